// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the scalar Kalman filter.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/scf_pkg.sv
// Package for the scalar Kalman filter: field widths, fixed-point formats,
// register indexes and reset values. No dependencies.
`default_nettype none

package scf_pkg;

   localparam int CHANNELS    = 2;
   localparam int CHAN_W      = 1;
   localparam int STORE_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int EST_W  = 40;   // signed, 30 fractional bits
   localparam int NOISE_W = 32;  // unsigned Q0.32
   localparam int COV_W  = 33;   // unsigned Q1.32
   localparam int PMID_W = 34;   // unsigned Q2.32
   localparam int DEN_W  = 35;
   localparam int REM_W  = 36;
   localparam int QUO_W  = 33;   // gain, Q1.32
   localparam int DIFF_W = 41;
   localparam int PROD_W = 65;
   localparam int ACC_W  = 42;
   localparam int DELTA_W = 43;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = 32'd4294967;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = 32'd214748365;

   localparam logic [QUO_W-1:0] GAIN_ONE = 33'h1_0000_0000;

endpackage

`default_nettype wire

// File: sv/scalar_kalman_filter.sv
// Top level of the per-channel scalar Kalman filter: sequencer, shared
// divider step, shared multiplier and channel state. Depends on scf_pkg.
//
//  channel  direction  handshake          payload
//  req_     in         tvalid / tready    tuser channel, tdata measurement
//  rsp_     out        tvalid / tready    tuser channel_out, tdata estimate
//  csr_     in         valid / ready      index, data (register write)
//
// An accepted beat passes through prediction, the denominator, the 33
// restoring division steps of the gain (skipped when p + q + r is zero), four
// passes of the one multiplier and a sign step before its result reaches the output register.
// The next beat is taken the cycle after the result is loaded, even while it waits.
// A stalled result holds the sequencer in its last step; reset clears it and the channel stores.
`default_nettype none

module scalar_kalman_filter
   import scf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [EST_W-1:0]       req_tdata,   // [39:0] measurement
   input  wire logic [CHAN_W-1:0]      req_tuser,   // [0] channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [EST_W-1:0]            rsp_tdata,   // [39:0] estimate
   output logic [CHAN_W-1:0]           rsp_tuser,   // [0] channel_out
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_PRED, S_DEN, S_DIV, S_MUL, S_ACC, S_SIGN, S_FIN
   } state_type;

   localparam logic [5:0] DIV_LAST = 6'(QUO_W - 1);

   state_type                 state_ff;
   logic [CHAN_W-1:0]         chan_ff;
   logic [STORE_IDX_W-1:0]    idx_ff;
   logic                      chan_ok_ff;
   logic [EST_W-1:0]          meas_ff;
   logic [EST_W-1:0]          est_ff;
   logic [COV_W-1:0]          p_ff;
   logic [PMID_W-1:0]         pmid_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [DIFF_W-1:0]         diff_ff;
   logic                      neg_ff;
   logic [DIFF_W-1:0]         mag_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [5:0]                cnt_ff;
   logic [1:0]                mstep_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic                      frac_ff;
   logic [COV_W-1:0]          pnew_ff;
   logic [DELTA_W-1:0]        delta_ff;
   logic [NOISE_W-1:0]        q_ff;
   logic [NOISE_W-1:0]        r_ff;
   logic [EST_W-1:0]          est_store_ff [CHANNELS];
   logic [COV_W-1:0]          cov_store_ff [CHANNELS];
   logic                      rsp_valid_ff;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic [EST_W-1:0]          rsp_est_ff;

   logic [STORE_IDX_W-1:0]    req_idx;
   logic                      req_chan_ok;
   logic [QUO_W-1:0]          one_minus_gain;
   logic [QUO_W-1:0]          mul_a;
   logic [NOISE_W-1:0]        mul_b;
   logic [PROD_W-1:0]         prod_in;
   logic [REM_W-1:0]          div_trial;
   logic                      div_ge;
   logic [REM_W-1:0]          rem_in;
   logic [ACC_W-1:0]          acc_sum;
   logic [DELTA_W-1:0]        nest_sum;
   logic [EST_W-1:0]          nest_in;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_est_ff;
   assign rsp_tuser  = rsp_chan_ff;

   assign req_idx     = STORE_IDX_W'(req_tuser);
   assign req_chan_ok = (int'(req_tuser) < CHANNELS);

   // Shared multiplier: covariance partial products first, then the estimate's.
   assign one_minus_gain = GAIN_ONE - quo_ff;

   always_comb begin
      case (mstep_ff)
         2'd0: begin
            mul_a = one_minus_gain;
            mul_b = pmid_ff[31:0];
         end
         2'd1: begin
            mul_a = one_minus_gain;
            mul_b = {30'd0, pmid_ff[33:32]};
         end
         2'd2: begin
            mul_a = quo_ff;
            mul_b = mag_ff[31:0];
         end
         default: begin
            mul_a = quo_ff;
            mul_b = {23'd0, mag_ff[40:32]};
         end
      endcase
   end

   assign prod_in = {32'd0, mul_a} * {33'd0, mul_b};

   // One restoring division step; the first step compares without shifting.
   assign div_trial = (cnt_ff == 6'd0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign div_ge    = (div_trial >= {1'b0, den_ff});
   assign rem_in    = div_ge ? (div_trial - {1'b0, den_ff}) : div_trial;

   assign acc_sum  = {9'd0, acc_ff[32:0]} + prod_ff[ACC_W-1:0];
   assign nest_sum = {{3{est_ff[EST_W-1]}}, est_ff} + delta_ff;

   always_comb begin
      if (nest_sum[42:39] == 4'b0000 || nest_sum[42:39] == 4'b1111) begin
         nest_in = nest_sum[EST_W-1:0];
      end else if (nest_sum[42]) begin
         nest_in = {1'b1, {(EST_W-1){1'b0}}};
      end else begin
         nest_in = {1'b0, {(EST_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff         <= PROCESS_NOISE_RESET;
         r_ff         <= MEASUREMENT_NOISE_RESET;
         mstep_ff     <= 2'd0;
         cnt_ff       <= 6'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            est_store_ff[i] <= '0;
            cov_store_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     q_ff <= csr_data;
               CSR_MEASUREMENT_NOISE: r_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_tready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  chan_ff    <= req_tuser;
                  idx_ff     <= req_idx;
                  chan_ok_ff <= req_chan_ok;
                  meas_ff    <= req_tdata;
                  if (req_chan_ok) begin
                     est_ff   <= est_store_ff[req_idx];
                     p_ff     <= cov_store_ff[req_idx];
                     state_ff <= S_PRED;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_PRED: begin
               pmid_ff  <= {1'b0, p_ff} + {2'd0, q_ff};
               diff_ff  <= {meas_ff[EST_W-1], meas_ff} - {est_ff[EST_W-1], est_ff};
               state_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff   <= {1'b0, pmid_ff} + {3'd0, r_ff};
               neg_ff   <= diff_ff[DIFF_W-1];
               mag_ff   <= diff_ff[DIFF_W-1] ? (~diff_ff + 41'd1) : diff_ff;
               rem_ff   <= {2'd0, pmid_ff};
               quo_ff   <= '0;
               cnt_ff   <= 6'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (den_ff == '0) begin
                  quo_ff   <= '0;
                  mstep_ff <= 2'd0;
                  state_ff <= S_MUL;
               end else begin
                  quo_ff <= {quo_ff[QUO_W-2:0], div_ge};
                  rem_ff <= rem_in;
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == DIV_LAST) begin
                     mstep_ff <= 2'd0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               case (mstep_ff)
                  2'd0: acc_ff <= {9'd0, prod_ff[64:32]};
                  2'd1: begin
                     pnew_ff <= (acc_sum[ACC_W-1:COV_W] != '0) ? '1 : acc_sum[COV_W-1:0];
                  end
                  2'd2: begin
                     frac_ff <= (prod_ff[31:0] != 32'd0);
                     acc_ff  <= {9'd0, prod_ff[64:32]};
                  end
                  default: acc_ff <= acc_sum;
               endcase
               mstep_ff <= mstep_ff + 2'd1;
               state_ff <= (mstep_ff == 2'd3) ? S_SIGN : S_MUL;
            end
            S_SIGN: begin
               // Truncation toward minus infinity: -(m + frac) = ~m + !frac.
               delta_ff <= neg_ff ? (~{1'b0, acc_ff} + {42'd0, ~frac_ff}) : {1'b0, acc_ff};
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_chan_ff  <= chan_ff;
                  if (chan_ok_ff) begin
                     rsp_est_ff           <= nest_in;
                     est_store_ff[idx_ff] <= nest_in;
                     cov_store_ff[idx_ff] <= pnew_ff;
                  end else begin
                     rsp_est_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: sv/scf_checker.sv
// Port-level checker for the scalar Kalman filter and its bind statement.
// Depends on scf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scf_checker
   import scf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [EST_W-1:0]       req_tdata,
   input wire logic [CHAN_W-1:0]      req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [EST_W-1:0]       rsp_tdata,
   input wire logic [CHAN_W-1:0]      rsp_tuser,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_IDX_W-1:0]   csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_data
);

   `ASSERT_CLK_RST(rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")
   `ASSERT_CLK_RST(busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "block ready again straight after taking a beat")
   `ASSERT_CLK_RST(rsp_needs_work, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready), "result appeared without work in progress")
   `ASSERT_CLK(rsp_clear_after_reset, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind scalar_kalman_filter scf_checker u_scf_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for scalar_kalman_filter. It predicts every filtered estimate
// in fixed point as it drives directed and random measurement beats under varied flow control.
// Depends on scf_pkg and the scalar_kalman_filter RTL.

module testbench;
   import scf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int SUM_W          = DELTA_W + 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 2'd3;
   localparam logic signed [EST_W-1:0] MEAS_MAX = {1'b0, {(EST_W-1){1'b1}}};
   localparam logic signed [EST_W-1:0] MEAS_MIN = {1'b1, {(EST_W-1){1'b0}}};
   localparam longint EST_HI = 64'sd549755813887;
   localparam longint EST_LO = -64'sd549755813888;

   typedef struct packed {
      logic [CHAN_W-1:0]       chan;
      logic signed [EST_W-1:0] est;
   } est_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [EST_W-1:0]      req_tdata;
   logic [CHAN_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [EST_W-1:0]      rsp_tdata;
   logic [CHAN_W-1:0]     rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [NOISE_W-1:0]      q_noise;
   logic [NOISE_W-1:0]      r_noise;
   logic signed [EST_W-1:0] est_state [CHANNELS];
   logic [COV_W-1:0]        cov_state [CHANNELS];

   est_beat_type pending_estimates [$];
   int        mismatches    = 0;
   int        quiet_cycles  = 0;
   int        send_idle_pct = 0;
   int        stall_pct     = 0;

   scalar_kalman_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One Kalman step on the predicted channel state; returns the new estimate.
   function automatic est_beat_type kalman_update(logic [CHAN_W-1:0] ch,
                                                  logic signed [EST_W-1:0] meas);
      logic [PMID_W-1:0]         p_mid;
      logic [DEN_W-1:0]          den;
      logic [QUO_W-1:0]          gain;
      logic [127:0]              cov_wide;
      logic signed [127:0]       prod;
      logic signed [DIFF_W-1:0]  diff;
      logic signed [DELTA_W-1:0] delta;
      logic signed [SUM_W-1:0]   sum;
      est_beat_type              beat;
      beat.chan = ch;
      beat.est  = '0;
      if (ch >= CHANNELS) return beat;
      p_mid = PMID_W'(cov_state[ch]) + PMID_W'(q_noise);
      den   = DEN_W'(p_mid) + DEN_W'(r_noise);
      if (den == '0) gain = '0;
      else gain = QUO_W'((128'(p_mid) << 32) / 128'(den));
      cov_wide = (128'(GAIN_ONE - gain) * 128'(p_mid)) >> 32;
      cov_state[ch] = (cov_wide > 128'h1_FFFF_FFFF) ? '1 : COV_W'(cov_wide);
      diff  = DIFF_W'(meas) - DIFF_W'(est_state[ch]);
      prod  = 128'($signed({1'b0, gain})) * 128'(diff);
      delta = DELTA_W'(prod >>> 32);
      sum   = SUM_W'(est_state[ch]) + SUM_W'(delta);
      if (sum > EST_HI) sum = SUM_W'(EST_HI);
      if (sum < EST_LO) sum = SUM_W'(EST_LO);
      est_state[ch] = EST_W'(sum);
      beat.est = est_state[ch];
      return beat;
   endfunction

   function automatic logic signed [EST_W-1:0] pick_measurement(logic [CHAN_W-1:0] ch);
      case ($urandom_range(7))
         0: return MEAS_MAX;
         1: return MEAS_MIN;
         2, 3: return est_state[ch] + $signed(24'($urandom));
         default: return EST_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [NOISE_W-1:0] pick_noise();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return NOISE_W'($urandom_range(1 << 20));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic wait_for_results();
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with no estimate outstanding.
   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_PROCESS_NOISE:     q_noise = value;
         CSR_MEASUREMENT_NOISE: r_noise = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_measurement(logic [CHAN_W-1:0] ch, logic signed [EST_W-1:0] meas);
      int gap;
      gap = 0;
      if (send_idle_pct > 0 && $urandom_range(15) == 0) gap = $urandom_range(50);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) @(negedge clock);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= meas;
      req_tuser  <= ch;
      do @(posedge clock); while (!req_tready);
      pending_estimates.push_back(kalman_update(ch, meas));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_estimates
      est_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_estimates.size() == 0) begin
            report_mismatch("beat with no estimate pending", 64'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_tuser !== want.chan)
               report_mismatch("channel_out", 64'(rsp_tuser), 64'(want.chan));
            if (rsp_tdata !== want.est)
               report_mismatch("estimate", 64'(rsp_tdata), 64'($unsigned(want.est)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("scalar_kalman_filter verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // With the covariance still zero after reset, q = r = 0 leaves the gain at zero.
   task automatic test_zero_denominator();
      write_register(CSR_PROCESS_NOISE, '0);
      write_register(CSR_MEASUREMENT_NOISE, '0);
      send_measurement(1'b0, MEAS_MAX);
      send_measurement(1'b1, MEAS_MIN);
      send_measurement(1'b0, '1);
   endtask

   // With r = 0 the gain is one, so the estimate jumps to the measurement.
   task automatic test_zero_measurement_noise();
      write_register(CSR_PROCESS_NOISE, '1);
      send_measurement(1'b0, MEAS_MAX);
      send_measurement(1'b1, MEAS_MIN);
      send_measurement(1'b0, '1);
      send_measurement(1'b1, '0);
   endtask

   task automatic test_unmapped_register_index();
      write_register(CSR_UNMAPPED_A, $urandom);
      write_register(CSR_UNMAPPED_B, $urandom);
      send_measurement(1'b1, EST_W'({$urandom, $urandom}));
      send_measurement(1'b0, EST_W'({$urandom, $urandom}));
   endtask

   task automatic test_noise_extremes();
      write_register(CSR_PROCESS_NOISE, '0);
      write_register(CSR_MEASUREMENT_NOISE, 32'd1);
      send_measurement(1'b0, MEAS_MIN);
      send_measurement(1'b1, MEAS_MAX);
      send_measurement(1'b0, MEAS_MAX);
      write_register(CSR_PROCESS_NOISE, '1);
      write_register(CSR_MEASUREMENT_NOISE, '1);
      send_measurement(1'b0, MEAS_MIN);
      send_measurement(1'b1, MEAS_MIN);
      send_measurement(1'b1, MEAS_MAX);
      write_register(CSR_PROCESS_NOISE, PROCESS_NOISE_RESET);
      write_register(CSR_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RESET);
      send_measurement(1'b0, '0);
      send_measurement(1'b1, 40'sd1 <<< 30);
      send_measurement(1'b0, -(40'sd1 <<< 30));
   endtask

   task automatic run_traffic_phase(int idle, int stall, int beats);
      logic [CHAN_W-1:0] ch;
      write_register(CSR_PROCESS_NOISE, pick_noise());
      write_register(CSR_MEASUREMENT_NOISE, pick_noise());
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (beats) begin
         if ($urandom_range(59) == 0) wait_for_results();
         ch = CHAN_W'($urandom_range(CHANNELS - 1));
         send_measurement(ch, pick_measurement(ch));
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0, 375);
      run_traffic_phase(81, 0, 375);
      run_traffic_phase(0, 81, 375);
      run_traffic_phase(6, 6, 375);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      q_noise    = PROCESS_NOISE_RESET;
      r_noise    = MEASUREMENT_NOISE_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         est_state[i] = '0;
         cov_state[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_denominator();
      test_zero_measurement_noise();
      test_unmapped_register_index();
      test_noise_extremes();
      test_random_traffic();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_estimates.size() == 0) begin
         $display("scalar_kalman_filter verification clean");
      end else begin
         $display("scalar_kalman_filter verification failed");
      end
      $finish;
   end

endmodule
